@@ hdl/ffba_pkg.sv @@
// package for the first-fit block allocator
// types and constants shared by the allocator modules; no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned GRAIN_LOG2 = 3;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } extent_t;

endpackage

@@ hdl/first_fit_block_allocator_core.sv @@
// top level of the first-fit block allocator
// Usage: one item per request on in_* (valid/ready); one result on out_*.
// Operations: allocate (round n to (n/8+1)*8, take first free extent that
// fits), free (look up address, return extent, merge free neighbors) and
// clear (one free extent covering the arena).
// Both extent lists sit in synchronous memories with registered read
// data. A list scan reads each entry (address, then compare) and a list
// shift moves each entry (read, then write).
// Zero size, clear and the unused code give their result the cycle after
// the item is taken. Allocate and free take time that grows with the
// scans and shifts they need.
// The sequencer handles one item at a time; in_ready is high only while
// idle, so a new item is taken at the earliest in the cycle after the result is taken.
// The result sits in output registers; while the receiver stalls the
// block holds it and accepts no new item until it is taken.
// Reset (rst_n low, synchronous) sets the free list to one extent covering
// the arena and empties the used list: free entry 0 reads as the whole
// arena until it is first written.
`timescale 1ns / 1ps

module first_fit_block_allocator_core #(
  parameter int unsigned ARENA_BYTES = 65536,
  parameter int unsigned LIST_DEPTH  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [15:0]                  in_request_bytes,
  input  logic [15:0]                  in_block_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_granted_address,
  output logic [16:0]                  out_granted_bytes,
  output logic [2:0]                   out_status
);
  import ffba_pkg::*;

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0]  FULL  = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0]  ONE   = CNT_W'(1);
  localparam logic [SIZE_W-1:0] ARENA = SIZE_W'(ARENA_BYTES);
  localparam extent_t RESET_EXT = '{addr: '0, size: ARENA};

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FSCAN = 10'b0000000010,
    S_FCHK  = 10'b0000000100,
    S_USCAN = 10'b0000001000,
    S_UCHK  = 10'b0000010000,
    S_MERGE = 10'b0000100000,
    S_MVRD  = 10'b0001000000,
    S_MVWR  = 10'b0010000000,
    S_PLACE = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]  ucnt_r, ucnt_nxt;
  logic              f0_ovl_r, f0_ovl_nxt; // free entry 0 reads as whole arena
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] baddr_r, baddr_nxt;
  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;           // scan index
  logic [CNT_W-1:0]  pos_r, pos_nxt;       // free slot of a returned extent
  logic [CNT_W-1:0]  uidx_r, uidx_nxt;     // used entry being freed
  logic [CNT_W-1:0]  slot_r, slot_nxt;     // insert position of a shift up
  logic [CNT_W-1:0]  j_r, j_nxt;           // shift destination
  extent_t           e_r, e_nxt;           // extent being granted or freed
  extent_t           prev_r, prev_nxt;     // free entry before the slot
  extent_t           nxt_r, nxt_nxt;       // free entry at the slot
  logic              nxt_ok_r, nxt_ok_nxt;
  extent_t           ins_r, ins_nxt;       // entry placed after a shift up
  logic              mv_free_r, mv_free_nxt;
  logic              mv_up_r, mv_up_nxt;
  logic [15:0]       ga_r, ga_nxt;
  logic [16:0]       gb_r, gb_nxt;
  status_t           st_r, st_nxt;
  logic              rd0_r;

  // memory ports
  logic              f_we, u_we;
  logic [IDX_W-1:0]  f_widx, f_ridx, u_widx, u_ridx;
  extent_t           f_wdata, u_wdata, frd_raw, frd, urd;

  logic              start_ins, start_udrop;
  logic              jp, jn, mv_more;
  logic [IDX_W-1:0]  mv_ridx;
  logic [CNT_W-1:0]  cnt_sel;
  extent_t           mv_data;
  logic [SIZE_W-1:0] need_c, split_addr;
  logic [SIZE_W:0]   prev_end, e_end;

  ffba_list_mem #(.DEPTH(LIST_DEPTH), .IDX_W(IDX_W)) u_free (
    .clk(clk), .wr_en(f_we), .wr_idx(f_widx), .wr_data(f_wdata),
    .rd_idx(f_ridx), .rd_data(frd_raw));
  ffba_list_mem #(.DEPTH(LIST_DEPTH), .IDX_W(IDX_W)) u_used (
    .clk(clk), .wr_en(u_we), .wr_idx(u_widx), .wr_data(u_wdata),
    .rd_idx(u_ridx), .rd_data(urd));

  // reset value of free entry 0 until it is written
  assign frd = rd0_r ? RESET_EXT : frd_raw;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_granted_address = ga_r;
  assign out_granted_bytes = gb_r;
  assign out_status = st_r;

  // rounded request size and extent ends
  assign need_c = {1'b0, in_request_bytes[ADDR_W-1:GRAIN_LOG2], {GRAIN_LOG2{1'b0}}}
                  + SIZE_W'(1 << GRAIN_LOG2);
  assign split_addr = {1'b0, frd.addr} + need_r;
  assign prev_end = {2'b00, prev_r.addr} + {1'b0, prev_r.size};
  assign e_end    = {2'b00, e_r.addr} + {1'b0, e_r.size};
  assign jp = (pos_r != '0) && (prev_end == {2'b00, e_r.addr});
  assign jn = nxt_ok_r && (e_end == {2'b00, nxt_r.addr});

  // shift helpers
  assign cnt_sel = mv_free_r ? fcnt_r : ucnt_r;
  assign mv_more = mv_up_r ? (j_r > slot_r) : (j_r + ONE < cnt_sel);
  assign mv_ridx = mv_up_r ? IDX_W'(j_r - ONE) : IDX_W'(j_r + ONE);
  assign mv_data = mv_free_r ? frd : urd;

  // sequencer next state and memory accesses
  always_comb begin
    state_nxt = state_r;
    fcnt_nxt = fcnt_r;
    ucnt_nxt = ucnt_r;
    f0_ovl_nxt = f0_ovl_r;
    op_nxt = op_r;
    baddr_nxt = baddr_r;
    need_nxt = need_r;
    i_nxt = i_r;
    pos_nxt = pos_r;
    uidx_nxt = uidx_r;
    slot_nxt = slot_r;
    j_nxt = j_r;
    e_nxt = e_r;
    prev_nxt = prev_r;
    nxt_nxt = nxt_r;
    nxt_ok_nxt = nxt_ok_r;
    ins_nxt = ins_r;
    mv_free_nxt = mv_free_r;
    mv_up_nxt = mv_up_r;
    ga_nxt = ga_r;
    gb_nxt = gb_r;
    st_nxt = st_r;
    start_ins = 1'b0;
    start_udrop = 1'b0;
    f_we = 1'b0;
    f_widx = j_r[IDX_W-1:0];
    f_wdata = mv_data;
    f_ridx = i_r[IDX_W-1:0];
    u_we = 1'b0;
    u_widx = j_r[IDX_W-1:0];
    u_wdata = mv_data;
    u_ridx = i_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = op_t'(in_operation);
          baddr_nxt = in_block_address;
          need_nxt = need_c;
          i_nxt = '0;
          ga_nxt = '0;
          gb_nxt = '0;
          st_nxt = ST_OK;
          unique case (op_t'(in_operation))
            OP_ALLOC: begin
              if (in_request_bytes == '0) begin
                st_nxt = ST_ZERO;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_FSCAN;
              end
            end
            OP_FREE: state_nxt = S_USCAN;
            OP_CLEAR: begin
              fcnt_nxt = ONE;
              ucnt_nxt = '0;
              f0_ovl_nxt = 1'b1;
              state_nxt = S_OUT;
            end
            OP_NONE: state_nxt = S_OUT;
          endcase
        end
      end
      // free list scan: read entry i
      S_FSCAN: begin
        if (i_r < fcnt_r) begin
          state_nxt = S_FCHK;
        end else if (op_r == OP_ALLOC) begin
          st_nxt = ST_NOFIT;
          state_nxt = S_OUT;
        end else begin
          pos_nxt = i_r;
          nxt_ok_nxt = 1'b0;
          state_nxt = S_MERGE;
        end
      end
      S_FCHK: begin
        if (op_r == OP_ALLOC) begin
          if (frd.size >= need_r) begin
            if (ucnt_r >= FULL) begin
              st_nxt = ST_FULL;
              state_nxt = S_OUT;
            end else begin
              e_nxt = frd;
              ga_nxt = frd.addr;
              gb_nxt = need_r;
              if (frd.size == need_r) begin
                // exact fit: drop the free entry
                mv_free_nxt = 1'b1;
                mv_up_nxt = 1'b0;
                j_nxt = i_r;
                state_nxt = S_MVRD;
              end else begin
                f_we = 1'b1;
                f_widx = i_r[IDX_W-1:0];
                f_wdata.addr = split_addr[ADDR_W-1:0];
                f_wdata.size = frd.size - need_r;
                i_nxt = '0;
                state_nxt = S_USCAN;
              end
            end
          end else begin
            i_nxt = i_r + ONE;
            state_nxt = S_FSCAN;
          end
        end else begin
          if (frd.addr > e_r.addr) begin
            pos_nxt = i_r;
            nxt_nxt = frd;
            nxt_ok_nxt = 1'b1;
            state_nxt = S_MERGE;
          end else begin
            prev_nxt = frd;
            i_nxt = i_r + ONE;
            state_nxt = S_FSCAN;
          end
        end
      end
      // used list scan: slot search or address match
      S_USCAN: begin
        if (i_r < ucnt_r) begin
          state_nxt = S_UCHK;
        end else if (op_r == OP_ALLOC) begin
          start_ins = 1'b1;
        end else begin
          st_nxt = ST_UNKNOWN;
          state_nxt = S_OUT;
        end
      end
      S_UCHK: begin
        if (op_r == OP_ALLOC) begin
          if (urd.addr > e_r.addr) begin
            start_ins = 1'b1;
          end else begin
            i_nxt = i_r + ONE;
            state_nxt = S_USCAN;
          end
        end else begin
          if (urd.addr == baddr_r) begin
            e_nxt = urd;
            uidx_nxt = i_r;
            i_nxt = '0;
            state_nxt = S_FSCAN;
          end else begin
            i_nxt = i_r + ONE;
            state_nxt = S_USCAN;
          end
        end
      end
      // merge a returned extent with its free neighbors
      S_MERGE: begin
        if (jp) begin
          f_we = 1'b1;
          f_widx = IDX_W'(pos_r - ONE);
          f_wdata.addr = prev_r.addr;
          if (jn) begin
            f_wdata.size = prev_r.size + e_r.size + nxt_r.size;
            mv_free_nxt = 1'b1;
            mv_up_nxt = 1'b0;
            j_nxt = pos_r;
            state_nxt = S_MVRD;
          end else begin
            f_wdata.size = prev_r.size + e_r.size;
            start_udrop = 1'b1;
          end
        end else if (jn) begin
          f_we = 1'b1;
          f_widx = pos_r[IDX_W-1:0];
          f_wdata.addr = e_r.addr;
          f_wdata.size = nxt_r.size + e_r.size;
          start_udrop = 1'b1;
        end else if (fcnt_r >= FULL) begin
          st_nxt = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          mv_free_nxt = 1'b1;
          mv_up_nxt = 1'b1;
          slot_nxt = pos_r;
          j_nxt = fcnt_r;
          ins_nxt = e_r;
          state_nxt = S_MVRD;
        end
      end
      // shift one entry: read its source
      S_MVRD: begin
        if (mv_more) begin
          f_ridx = mv_ridx;
          u_ridx = mv_ridx;
          state_nxt = S_MVWR;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      // shift one entry: write its destination
      S_MVWR: begin
        if (mv_free_r) begin
          f_we = 1'b1;
        end else begin
          u_we = 1'b1;
        end
        j_nxt = mv_up_r ? j_r - ONE : j_r + ONE;
        state_nxt = S_MVRD;
      end
      // finish a shift and chain to the next step of the item
      S_PLACE: begin
        if (mv_up_r) begin
          if (mv_free_r) begin
            f_we = 1'b1;
            f_widx = slot_r[IDX_W-1:0];
            f_wdata = ins_r;
            fcnt_nxt = fcnt_r + ONE;
          end else begin
            u_we = 1'b1;
            u_widx = slot_r[IDX_W-1:0];
            u_wdata = ins_r;
            ucnt_nxt = ucnt_r + ONE;
          end
        end else if (mv_free_r) begin
          fcnt_nxt = fcnt_r - ONE;
        end else begin
          ucnt_nxt = ucnt_r - ONE;
        end
        if (!mv_free_r) begin
          state_nxt = S_OUT;
        end else if (op_r == OP_ALLOC) begin
          i_nxt = '0;
          state_nxt = S_USCAN;
        end else begin
          start_udrop = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // record a grant in the used list
    if (start_ins) begin
      mv_free_nxt = 1'b0;
      mv_up_nxt = 1'b1;
      slot_nxt = i_r;
      j_nxt = ucnt_r;
      ins_nxt.addr = e_r.addr;
      ins_nxt.size = need_r;
      state_nxt = S_MVRD;
    end
    // remove a freed extent from the used list
    if (start_udrop) begin
      mv_free_nxt = 1'b0;
      mv_up_nxt = 1'b0;
      j_nxt = uidx_r;
      state_nxt = S_MVRD;
    end
    if (f_we && f_widx == '0) begin
      f0_ovl_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fcnt_r   <= ONE;
      ucnt_r   <= '0;
      f0_ovl_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      fcnt_r   <= fcnt_nxt;
      ucnt_r   <= ucnt_nxt;
      f0_ovl_r <= f0_ovl_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    baddr_r   <= baddr_nxt;
    need_r    <= need_nxt;
    i_r       <= i_nxt;
    pos_r     <= pos_nxt;
    uidx_r    <= uidx_nxt;
    slot_r    <= slot_nxt;
    j_r       <= j_nxt;
    e_r       <= e_nxt;
    prev_r    <= prev_nxt;
    nxt_r     <= nxt_nxt;
    nxt_ok_r  <= nxt_ok_nxt;
    ins_r     <= ins_nxt;
    mv_free_r <= mv_free_nxt;
    mv_up_r   <= mv_up_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    st_r      <= st_nxt;
    rd0_r     <= f0_ovl_r && (f_ridx == '0);
  end

endmodule

@@ hdl/ffba_list_mem.sv @@
// one sorted extent list held in a synchronous memory
// one write and one read port, read data registered; uses ffba_pkg
`timescale 1ns / 1ps

module ffba_list_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_idx,
  input  ffba_pkg::extent_t       wr_data,
  input  logic [IDX_W-1:0]        rd_idx,
  output ffba_pkg::extent_t       rd_data
);
  import ffba_pkg::*;

  extent_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule
